[hdl/qve_pkg.sv]
package qve_pkg;

	// Store and name geometry
	localparam int NAME_MAX = 16;
	localparam int NAME_AW  = $clog2(NAME_MAX);
	localparam int OUT_MAX  = 64;
	localparam int VAL_AW   = $clog2(OUT_MAX);

	// Queue between front and back
	localparam int Q_DEPTH = 4;
	localparam int Q_AW    = $clog2(Q_DEPTH);

	// Configuration register indexes
	localparam logic [2:0] CFG_NAME_LOW  = 3'd0;
	localparam logic [2:0] CFG_NAME_HIGH = 3'd1;
	localparam logic [2:0] CFG_NAME_LEN  = 3'd2;
	localparam logic [2:0] CFG_FORM      = 3'd3;
	localparam logic [2:0] CFG_OUT_LIMIT = 3'd4;

	// Character codes
	localparam logic [7:0] CH_PCT   = 8'h25;
	localparam logic [7:0] CH_PLUS  = 8'h2b;
	localparam logic [7:0] CH_AMP   = 8'h26;
	localparam logic [7:0] CH_EQ    = 8'h3d;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_W     = 8'h57;
	localparam logic [7:0] CH_MASK  = 8'hff;

	typedef enum logic {
		OP_WRITE,
		OP_DRAIN
	} op_kind_t;

	// One queued operation: a store write, or a drain of arg bytes
	typedef struct packed {
		op_kind_t           kind;
		logic [VAL_AW-1:0]  arg;
		logic [7:0]         data;
		logic               found;
		logic               complete;
	} op_t;

	// Effective configuration seen by the front
	typedef struct packed {
		logic [NAME_MAX-1:0][7:0] name;
		logic [NAME_AW:0]         len;
		logic                     form;
		logic [VAL_AW-1:0]        cap;
	} cfg_t;

endpackage

[hdl/qve_if.sv]
interface qve_buffer_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       has_byte;
	logic       is_end;

	modport source (output valid, data_byte, has_byte, is_end, input ready);
	modport sink (input valid, data_byte, has_byte, is_end, output ready);
endinterface

interface qve_result_if;
	logic       valid;
	logic       ready;
	logic [7:0] value_byte;
	logic       byte_valid;
	logic       last_of_run;
	logic       found;
	logic       complete;
	logic [5:0] value_length;

	modport source (output valid, value_byte, byte_valid, last_of_run, found, complete,
		value_length, input ready);
	modport sink (input valid, value_byte, byte_valid, last_of_run, found, complete,
		value_length, output ready);
endinterface

[hdl/query_variable_extractor_core.sv]
// Query variable extractor.
// Buffer channel (valid/ready): one request per buffer byte, with has_byte
// set for a real byte and is_end set on the last request of the buffer (it
// may carry a byte or be a bare end marker). Bytes are taken one per cycle
// while the op queue takes ops; a byte that closes a broken escape writes
// up to three store bytes and holds the channel while its ops are queued.
// Result channel (valid/ready): after each end marker, one request per
// decoded value byte, or one request with byte_valid low for an empty value
// or no match; last_of_run marks the final one, and every request carries
// found, complete and value_length.
// The first result follows the end marker through the op queue, behind any
// store writes queued ahead of it; then one result per cycle while the
// result channel is ready, set by the single read port of the value store.
// A stalled result channel holds its output register; a four-entry op queue
// keeps taking bytes until it fills.
// Reset clears scan state and queues and loads the register reset values;
// the value store needs no clearing pass. Configuration writes (cfg_we,
// cfg_index, cfg_data) take effect at once and belong between buffers.
module query_variable_extractor_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data,
	qve_buffer_if.sink  buffer,
	qve_result_if.source result
);
	import qve_pkg::*;

	logic [63:0] name_low_q;
	logic [63:0] name_high_q;
	logic [4:0]  name_len_q;
	logic        form_q;
	logic [6:0]  out_limit_q;
	cfg_t        cfg;

	logic        push_valid;
	logic        push_ready;
	op_t         push_op;
	logic        pop_valid;
	logic        pop_ready;
	op_t         pop_op;

	// Hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			name_low_q  <= '0;
			name_high_q <= '0;
			name_len_q  <= '0;
			form_q      <= 1'b0;
			out_limit_q <= 7'd64;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_NAME_LOW:  name_low_q  <= cfg_data;
				CFG_NAME_HIGH: name_high_q <= cfg_data;
				CFG_NAME_LEN:  name_len_q  <= cfg_data[4:0];
				CFG_FORM:      form_q      <= cfg_data[0];
				CFG_OUT_LIMIT: out_limit_q <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	// Saturate name length and derive store capacity
	always_comb begin
		cfg.name = {name_high_q, name_low_q};
		cfg.form = form_q;
		if (name_len_q > 5'(NAME_MAX)) cfg.len = (NAME_AW+1)'(NAME_MAX);
		else cfg.len = name_len_q;
		if (out_limit_q == '0) cfg.cap = '0;
		else if (out_limit_q >= 7'(OUT_MAX)) cfg.cap = VAL_AW'(OUT_MAX - 1);
		else cfg.cap = out_limit_q[VAL_AW-1:0] - 1'b1;
	end

	qve_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.buffer     (buffer),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_op    (push_op)
	);

	qve_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_op    (push_op),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_op     (pop_op)
	);

	qve_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_op    (pop_op),
		.result    (result)
	);

endmodule

[hdl/qve_front.sv]
module qve_front (
	input  logic          clk,
	input  logic          arst_n,
	input  qve_pkg::cfg_t cfg,
	qve_buffer_if.sink    buffer,
	output logic          push_valid,
	input  logic          push_ready,
	output qve_pkg::op_t  push_op
);
	import qve_pkg::*;

	typedef enum logic [1:0] {
		PH_COMPARE,
		PH_SKIP,
		PH_VALUE
	} phase_t;

	typedef enum logic [1:0] {
		ESC_NONE,
		ESC_PCT,
		ESC_DIGIT
	} esc_t;

	// Running count plus the store writes one request produces
	typedef struct packed {
		logic [VAL_AW-1:0]        cnt;
		logic                     cmp;
		logic [1:0]               nwr;
		logic [2:0][7:0]          wd;
		logic [2:0][VAL_AW-1:0]   wa;
	} acc_t;

	function automatic logic is_hex(logic [7:0] b);
		return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h61 && b <= 8'h66) ||
			(b >= 8'h41 && b <= 8'h46);
	endfunction

	function automatic logic [3:0] hex_val(logic [7:0] b);
		logic [7:0] t;
		begin
			t = (b | CH_SPACE) - CH_W;
			if (b >= 8'h30 && b <= 8'h39) t = b;
			return t[3:0];
		end
	endfunction

	function automatic acc_t put_byte(acc_t a, logic [7:0] b, logic [VAL_AW-1:0] cap);
		acc_t r;
		begin
			r = a;
			if (a.cnt < cap) begin
				r.wd[a.nwr] = b;
				r.wa[a.nwr] = a.cnt;
				r.nwr       = a.nwr + 2'd1;
				r.cnt       = a.cnt + VAL_AW'(1);
			end else begin
				r.cmp = 1'b0;
			end
			return r;
		end
	endfunction

	function automatic acc_t flush_esc(acc_t a, esc_t e, logic [7:0] h,
		logic [VAL_AW-1:0] cap);
		acc_t r;
		begin
			r = a;
			if (e == ESC_PCT) begin
				r = put_byte(r, CH_PCT, cap);
			end else if (e == ESC_DIGIT) begin
				r = put_byte(r, CH_PCT, cap);
				r = put_byte(r, h, cap);
			end
			return r;
		end
	endfunction

	phase_t            ph_q;
	esc_t              esc_q;
	logic [NAME_AW:0]  pos_q;
	logic [7:0]        held_q;
	logic [VAL_AW-1:0] cnt_q;
	logic              fnd_q;
	logic              cmp_q;

	op_t  [3:0]        ops_q;
	logic [2:0]        pend_q;

	acc_t              a;
	phase_t            ph_n;
	esc_t              esc_n;
	logic [NAME_AW:0]  pos_n;
	logic [7:0]        held_n;
	logic              fnd_n;
	op_t  [3:0]        ops_d;
	logic [2:0]        nops_d;
	logic [7:0]        b;
	logic              accept;
	logic              push;

	assign b      = buffer.data_byte;
	assign push   = push_valid && push_ready;
	assign buffer.ready = (pend_q == 3'd0) || (pend_q == 3'd1 && push_ready);
	assign accept = buffer.valid && buffer.ready;

	// Classify one request: scan state update and the store writes it causes
	always_comb begin
		a       = '0;
		a.cnt   = cnt_q;
		a.cmp   = cmp_q;
		ph_n    = ph_q;
		esc_n   = esc_q;
		pos_n   = pos_q;
		held_n  = held_q;
		fnd_n   = fnd_q;
		if (buffer.has_byte) begin
			unique case (ph_q)
				PH_VALUE: begin
					if (b == CH_AMP) begin
						a     = flush_esc(a, esc_q, held_q, cfg.cap);
						esc_n = ESC_NONE;
						ph_n  = PH_COMPARE;
						pos_n = '0;
					end else if (esc_q == ESC_PCT && is_hex(b)) begin
						held_n = b;
						esc_n  = ESC_DIGIT;
					end else if (esc_q == ESC_DIGIT && is_hex(b)) begin
						a     = put_byte(a, {hex_val(held_q), hex_val(b)}, cfg.cap);
						esc_n = ESC_NONE;
					end else begin
						a     = flush_esc(a, esc_q, held_q, cfg.cap);
						esc_n = ESC_NONE;
						if (a.cnt >= cfg.cap) begin
							a.cmp = 1'b0;
						end else if (b == CH_PCT) begin
							esc_n = ESC_PCT;
						end else if (cfg.form && b == CH_PLUS) begin
							a = put_byte(a, CH_SPACE, cfg.cap);
						end else begin
							a = put_byte(a, b, cfg.cap);
						end
					end
				end
				PH_COMPARE: begin
					if (pos_q < cfg.len) begin
						if (b == cfg.name[pos_q[NAME_AW-1:0]]) pos_n = pos_q + 1'b1;
						else if (b == CH_AMP) pos_n = '0;
						else ph_n = PH_SKIP;
					end else if (b == CH_EQ) begin
						fnd_n = 1'b1;
						a.cmp = 1'b1;
						a.cnt = '0;
						esc_n = ESC_NONE;
						ph_n  = PH_VALUE;
					end else if (b == CH_AMP) begin
						pos_n = '0;
					end else begin
						ph_n = PH_SKIP;
					end
				end
				PH_SKIP: begin
					if (b == CH_AMP) begin
						ph_n  = PH_COMPARE;
						pos_n = '0;
					end
				end
				default: ph_n = ph_q;
			endcase
		end
		// Flush a pending escape at the buffer end
		if (buffer.is_end && ph_n == PH_VALUE) begin
			a = flush_esc(a, esc_n, held_n, cfg.cap);
		end
		// Build the op list: writes first, then the drain
		for (int i = 0; i < 4; i++) begin
			ops_d[i].kind     = OP_DRAIN;
			ops_d[i].arg      = a.cnt;
			ops_d[i].data     = '0;
			ops_d[i].found    = fnd_n;
			ops_d[i].complete = a.cmp;
		end
		for (int i = 0; i < 3; i++) begin
			if (2'(i) < a.nwr) begin
				ops_d[i].kind = OP_WRITE;
				ops_d[i].arg  = a.wa[i];
				ops_d[i].data = a.wd[i] & CH_MASK;
			end
		end
		nops_d = {1'b0, a.nwr} + {2'b0, buffer.is_end};
	end

	// Hold scan state; clear it on the end marker
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q   <= PH_COMPARE;
			esc_q  <= ESC_NONE;
			pos_q  <= '0;
			held_q <= '0;
			cnt_q  <= '0;
			fnd_q  <= 1'b0;
			cmp_q  <= 1'b0;
			pend_q <= '0;
		end else begin
			if (accept) begin
				if (buffer.is_end) begin
					ph_q   <= PH_COMPARE;
					esc_q  <= ESC_NONE;
					pos_q  <= '0;
					held_q <= '0;
					cnt_q  <= '0;
					fnd_q  <= 1'b0;
					cmp_q  <= 1'b0;
				end else begin
					ph_q   <= ph_n;
					esc_q  <= esc_n;
					pos_q  <= pos_n;
					held_q <= held_n;
					cnt_q  <= a.cnt;
					fnd_q  <= fnd_n;
					cmp_q  <= a.cmp;
				end
				pend_q <= nops_d;
			end else if (push) begin
				pend_q <= pend_q - 3'd1;
			end
		end
	end

	// Load new ops or advance the pending list
	always_ff @(posedge clk) begin
		if (accept) begin
			ops_q <= ops_d;
		end else if (push) begin
			ops_q[0] <= ops_q[1];
			ops_q[1] <= ops_q[2];
			ops_q[2] <= ops_q[3];
		end
	end

	assign push_valid = (pend_q != 3'd0);
	assign push_op    = ops_q[0];

endmodule

[hdl/qve_fifo.sv]
module qve_fifo (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push_valid,
	output logic         push_ready,
	input  qve_pkg::op_t push_op,
	output logic         pop_valid,
	input  logic         pop_ready,
	output qve_pkg::op_t pop_op
);
	import qve_pkg::*;

	op_t [Q_DEPTH-1:0] slots_q;
	logic [Q_AW-1:0]   wr_q;
	logic [Q_AW-1:0]   rd_q;
	logic [Q_AW:0]     cnt_q;
	logic              push;
	logic              pop;

	assign push_ready = (cnt_q != (Q_AW+1)'(Q_DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_op     = slots_q[rd_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	// Store the pushed op
	always_ff @(posedge clk) begin
		if (push) slots_q[wr_q] <= push_op;
	end

endmodule

[hdl/qve_back.sv]
module qve_back (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         pop_valid,
	output logic         pop_ready,
	input  qve_pkg::op_t pop_op,
	qve_result_if.source result
);
	import qve_pkg::*;

	typedef struct packed {
		logic              bvalid;
		logic              last;
		logic              found;
		logic              complete;
		logic [VAL_AW-1:0] len;
	} meta_t;

	logic [7:0]        mem [OUT_MAX];

	logic              draining_q;
	logic [VAL_AW-1:0] idx_q;
	logic [VAL_AW-1:0] n_q;
	logic              fnd_q;
	logic              cmp_q;

	logic              rdv_s1;
	logic [7:0]        rd_data_s1;
	meta_t             meta_s1;

	logic              out_valid_q;
	logic [7:0]        out_byte_q;
	meta_t             out_meta_q;

	logic              pop;
	logic              out_free;
	logic              issue;
	logic              last_issue;

	assign pop_ready  = !draining_q;
	assign pop        = pop_valid && pop_ready;
	assign out_free   = !out_valid_q || result.ready;
	assign issue      = draining_q && (!rdv_s1 || out_free);
	assign last_issue = (n_q == '0) || ({1'b0, idx_q} + 1'b1 == {1'b0, n_q});

	// Store writes and registered drain reads
	always_ff @(posedge clk) begin
		if (pop && pop_op.kind == OP_WRITE) mem[pop_op.arg] <= pop_op.data;
		if (issue) rd_data_s1 <= mem[idx_q];
	end

	// Sequence the drain and the read and output stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			draining_q  <= 1'b0;
			idx_q       <= '0;
			n_q         <= '0;
			fnd_q       <= 1'b0;
			cmp_q       <= 1'b0;
			rdv_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop && pop_op.kind == OP_DRAIN) begin
				draining_q <= 1'b1;
				idx_q      <= '0;
				n_q        <= pop_op.arg;
				fnd_q      <= pop_op.found;
				cmp_q      <= pop_op.complete;
			end else if (issue) begin
				idx_q <= idx_q + 1'b1;
				if (last_issue) draining_q <= 1'b0;
			end
			if (issue) rdv_s1 <= 1'b1;
			else if (out_free) rdv_s1 <= 1'b0;
			if (rdv_s1 && out_free) out_valid_q <= 1'b1;
			else if (result.ready) out_valid_q <= 1'b0;
		end
	end

	// Hold result payload while the receiver stalls
	always_ff @(posedge clk) begin
		if (issue) begin
			meta_s1.bvalid   <= (n_q != '0);
			meta_s1.last     <= last_issue;
			meta_s1.found    <= fnd_q;
			meta_s1.complete <= cmp_q;
			meta_s1.len      <= n_q;
		end
		if (rdv_s1 && out_free) begin
			out_byte_q <= meta_s1.bvalid ? rd_data_s1 : 8'h00;
			out_meta_q <= meta_s1;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.value_byte   = out_byte_q;
	assign result.byte_valid   = out_meta_q.bvalid;
	assign result.last_of_run  = out_meta_q.last;
	assign result.found        = out_meta_q.found;
	assign result.complete     = out_meta_q.complete;
	assign result.value_length = out_meta_q.len;

`ifndef SYNTHESIS
	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_meta_q.bvalid |-> out_meta_q.last && out_meta_q.len == '0)
		else $error("empty result not a single last item");
	a_byte_needs_found: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_meta_q.bvalid |-> out_meta_q.found)
		else $error("value byte without a match");
	a_no_pop_in_drain: assert property (@(posedge clk) disable iff (!arst_n)
		draining_q |-> !pop)
		else $error("op popped during drain");
	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		rdv_s1 && !out_free |=> rdv_s1 && $stable(rd_data_s1))
		else $error("read stage lost data under stall");
`endif

endmodule
